[hw/rtl/tglrs_pkg.sv]
// Shared types, codes and constants of the throttle glide-lock and roll-test sequencer.
`timescale 1ns / 1ps

package tglrs_pkg;

	// Request codes carried in req_type
	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_HALL = 2'd1;
	localparam logic [1:0] REQ_CTRL = 2'd2;

	// Register indexes on the configuration port
	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_THROTTLE_FLOOR      = 3'd0;
	localparam logic [2:0] REG_HOMING_THROTTLE     = 3'd1;
	localparam logic [2:0] REG_RAMP_STEP           = 3'd2;
	localparam logic [2:0] REG_ROLL_START_PERIODS  = 3'd3;
	localparam logic [2:0] REG_ROLL_LENGTH_PERIODS = 3'd4;
	localparam logic [2:0] REG_ROLL_OFFSET         = 3'd5;
	localparam logic [2:0] REG_HOLD_MODE           = 3'd6;

	// Throttle used in hold when hall rearm is off
	localparam logic [15:0] IDLE_THROTTLE = 16'd900;

	// Reported state codes
	localparam logic [1:0] GLIDE_CODE_FOLLOW = 2'd0;
	localparam logic [1:0] GLIDE_CODE_HOMING = 2'd1;
	localparam logic [1:0] GLIDE_CODE_HOLD   = 2'd2;
	localparam logic [1:0] ROLL_CODE_WAIT    = 2'd0;
	localparam logic [1:0] ROLL_CODE_DELAY   = 2'd1;
	localparam logic [1:0] ROLL_CODE_PULSE   = 2'd2;
	localparam logic [1:0] ROLL_CODE_DONE    = 2'd3;

	typedef enum logic [2:0] {
		GLIDE_FOLLOW = 3'b001,
		GLIDE_HOMING = 3'b010,
		GLIDE_HOLD   = 3'b100
	} glide_state_t;

	typedef enum logic [3:0] {
		ROLL_WAIT   = 4'b0001,
		ROLL_LEADIN = 4'b0010,
		ROLL_PULSE  = 4'b0100,
		ROLL_DONE   = 4'b1000
	} roll_state_t;

	typedef struct packed {
		logic [15:0]        throttle_floor;
		logic [15:0]        homing_throttle;
		logic [15:0]        ramp_step;
		logic [7:0]         roll_start_periods;
		logic [7:0]         roll_length_periods;
		logic signed [12:0] roll_offset;
		logic               hold_mode;
	} cfg_t;

	function automatic logic [1:0] glide_code(glide_state_t s);
		logic [1:0] c;
		unique case (s)
			GLIDE_FOLLOW: c = GLIDE_CODE_FOLLOW;
			GLIDE_HOMING: c = GLIDE_CODE_HOMING;
			default:      c = GLIDE_CODE_HOLD;
		endcase
		return c;
	endfunction

	function automatic logic [1:0] roll_code(roll_state_t s);
		logic [1:0] c;
		unique case (s)
			ROLL_WAIT:   c = ROLL_CODE_WAIT;
			ROLL_LEADIN: c = ROLL_CODE_DELAY;
			ROLL_PULSE:  c = ROLL_CODE_PULSE;
			default:     c = ROLL_CODE_DONE;
		endcase
		return c;
	endfunction

endpackage

[hw/rtl/tglrs_req_if.sv]
// Request channel: valid/ready handshake with the input item fields.
`timescale 1ns / 1ps

interface tglrs_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [15:0] throttle_in;
	logic [15:0] left_aileron_in;
	logic [15:0] right_aileron_in;
	logic        glide_enable;
	logic        roll_enable;

	modport source (
		output valid, req_type, throttle_in, left_aileron_in, right_aileron_in,
		       glide_enable, roll_enable,
		input  ready
	);

	modport sink (
		input  valid, req_type, throttle_in, left_aileron_in, right_aileron_in,
		       glide_enable, roll_enable,
		output ready
	);
endinterface

[hw/rtl/tglrs_res_if.sv]
// Result channel: valid/ready handshake with the servo command fields.
`timescale 1ns / 1ps

interface tglrs_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] throttle_out;
	logic [15:0] left_aileron_out;
	logic [15:0] right_aileron_out;
	logic [1:0]  glide_state_out;
	logic [1:0]  roll_state_out;

	modport source (
		output valid, throttle_out, left_aileron_out, right_aileron_out,
		       glide_state_out, roll_state_out,
		input  ready
	);

	modport sink (
		input  valid, throttle_out, left_aileron_out, right_aileron_out,
		       glide_state_out, roll_state_out,
		output ready
	);
endinterface

[hw/rtl/tglrs_regs.sv]
// APB-style configuration register file of the sequencer.
`timescale 1ns / 1ps

module tglrs_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tglrs_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output tglrs_pkg::cfg_t             cfg
);
	import tglrs_pkg::*;

	logic [2:0] index;
	logic       wr_en;

	assign index  = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	// Write on the access cycle of a write transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.throttle_floor      <= '0;
			cfg.homing_throttle     <= '0;
			cfg.ramp_step           <= 16'd1;
			cfg.roll_start_periods  <= '0;
			cfg.roll_length_periods <= '0;
			cfg.roll_offset         <= '0;
			cfg.hold_mode           <= 1'b0;
		end else if (wr_en) begin
			unique case (index)
				REG_THROTTLE_FLOOR:      cfg.throttle_floor      <= pwdata[15:0];
				REG_HOMING_THROTTLE:     cfg.homing_throttle     <= pwdata[15:0];
				REG_RAMP_STEP:           cfg.ramp_step           <= pwdata[15:0];
				REG_ROLL_START_PERIODS:  cfg.roll_start_periods  <= pwdata[7:0];
				REG_ROLL_LENGTH_PERIODS: cfg.roll_length_periods <= pwdata[7:0];
				REG_ROLL_OFFSET:         cfg.roll_offset         <= pwdata[12:0];
				REG_HOLD_MODE:           cfg.hold_mode           <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back, zero extended
	always_comb begin
		unique case (index)
			REG_THROTTLE_FLOOR:      prdata = {16'd0, cfg.throttle_floor};
			REG_HOMING_THROTTLE:     prdata = {16'd0, cfg.homing_throttle};
			REG_RAMP_STEP:           prdata = {16'd0, cfg.ramp_step};
			REG_ROLL_START_PERIODS:  prdata = {24'd0, cfg.roll_start_periods};
			REG_ROLL_LENGTH_PERIODS: prdata = {24'd0, cfg.roll_length_periods};
			REG_ROLL_OFFSET:         prdata = {19'd0, cfg.roll_offset};
			REG_HOLD_MODE:           prdata = {31'd0, cfg.hold_mode};
			default:                 prdata = '0;
		endcase
	end

endmodule

[hw/rtl/throttle_glide_lock_and_roll_sequencer.sv]
// Top level of the throttle glide-lock and roll-test sequencer.
`timescale 1ns / 1ps

// Takes one transaction per clock on req: timer ticks and hall edges update the
// internal counters and periods and give no result; each control update gives
// one result on res, passing through the input register and then loaded into the
// result register together with the state registers. The sustained rate is one
// item per cycle; req only stalls when a control update waits behind a result
// that res has not yet taken. The glide lock starts in hold after reset. The
// registers on the APB port must be written only while no transaction is in
// flight; the block itself does not enforce this. A write takes effect at the
// access cycle.
module throttle_glide_lock_and_roll_sequencer #(
	parameter logic [15:0] LEFT_NEUTRAL  = 16'd1500,
	parameter logic [15:0] RIGHT_NEUTRAL = 16'd1500
) (
	input  logic                        clk,
	input  logic                        arst_n,
	tglrs_req_if.sink                   req,
	tglrs_res_if.source                 res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tglrs_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import tglrs_pkg::*;

	cfg_t cfg;

	tglrs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input stage
	logic        valid_s1;
	logic [1:0]  req_type_s1;
	logic [15:0] throttle_s1;
	logic [15:0] left_s1;
	logic [15:0] right_s1;
	logic        glide_en_s1;
	logic        roll_en_s1;

	// Sequencer state
	glide_state_t glide_q;
	roll_state_t  roll_q;
	logic [15:0]  target_q;
	logic [15:0]  level_q;
	logic         hall_seen_q;
	logic [15:0]  edge_ticks_q;
	logic [15:0]  last_period_q;
	logic [15:0]  avg_period_q;
	logic [31:0]  roll_ticks_q;
	logic [24:0]  start_mark_q;
	logic [24:0]  end_mark_q;
	logic         glide_was_q;
	logic         roll_was_q;

	logic advance;
	logic is_ctrl_s1;

	assign is_ctrl_s1 = (req_type_s1 == REQ_CTRL);
	assign advance    = valid_s1 && (!is_ctrl_s1 || !res.valid || res.ready);
	assign req.ready  = !valid_s1 || advance;

	// Capture an accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_type_s1 <= req.req_type;
			throttle_s1 <= req.throttle_in;
			left_s1     <= req.left_aileron_in;
			right_s1    <= req.right_aileron_in;
			glide_en_s1 <= req.glide_enable;
			roll_en_s1  <= req.roll_enable;
		end
	end

	// Next state of a control update
	glide_state_t glide_nxt;
	roll_state_t  roll_nxt;
	logic [15:0]  target_nxt;
	logic [15:0]  level_nxt;
	logic [31:0]  roll_ticks_nxt;
	logic [24:0]  start_mark_nxt;
	logic [24:0]  end_mark_nxt;
	logic [15:0]  thr_res;
	logic [15:0]  left_res;
	logic [15:0]  right_res;
	logic [16:0]  ramp_sum;
	logic [23:0]  start_prod;
	logic [23:0]  length_prod;

	assign start_prod  = {16'd0, cfg.roll_start_periods} * {8'd0, avg_period_q};
	assign length_prod = {16'd0, cfg.roll_length_periods} * {8'd0, avg_period_q};

	always_comb begin
		glide_nxt      = glide_q;
		roll_nxt       = roll_q;
		target_nxt     = target_q;
		level_nxt      = level_q;
		roll_ticks_nxt = roll_ticks_q;
		start_mark_nxt = start_mark_q;
		end_mark_nxt   = end_mark_q;
		thr_res        = throttle_s1;
		left_res       = left_s1;
		right_res      = right_s1;
		ramp_sum       = '0;

		// Glide lock: states fall through within one update
		if (glide_en_s1) begin
			if (!glide_was_q) glide_nxt = GLIDE_FOLLOW;
			if (glide_nxt == GLIDE_FOLLOW) begin
				if (throttle_s1 < cfg.throttle_floor) glide_nxt = GLIDE_HOMING;
				else target_nxt = throttle_s1;
			end
			if (glide_nxt == GLIDE_HOMING) begin
				if (throttle_s1 > cfg.throttle_floor) begin
					glide_nxt  = GLIDE_FOLLOW;
					target_nxt = throttle_s1;
				end else if (hall_seen_q) begin
					glide_nxt = GLIDE_HOLD;
				end else begin
					target_nxt = cfg.homing_throttle;
				end
			end
			if (glide_nxt == GLIDE_HOLD) begin
				if (throttle_s1 > cfg.throttle_floor) begin
					glide_nxt  = GLIDE_FOLLOW;
					target_nxt = throttle_s1;
				end else if (cfg.hold_mode) begin
					if (hall_seen_q) begin
						glide_nxt  = GLIDE_HOMING;
						target_nxt = cfg.homing_throttle;
					end
				end else begin
					target_nxt = IDLE_THROTTLE;
				end
			end
			// Rise-limited ramp, drop at once
			ramp_sum = {1'b0, level_q} + {1'b0, cfg.ramp_step};
			if (ramp_sum > {1'b0, target_nxt}) level_nxt = target_nxt;
			else level_nxt = ramp_sum[15:0];
			thr_res = level_nxt;
		end

		// Roll test sequence
		if (roll_en_s1) begin
			if (!roll_was_q) roll_nxt = ROLL_WAIT;
			left_res  = LEFT_NEUTRAL;
			right_res = RIGHT_NEUTRAL;
			if (roll_nxt == ROLL_WAIT && hall_seen_q) begin
				roll_nxt       = ROLL_LEADIN;
				roll_ticks_nxt = '0;
				start_mark_nxt = {1'b0, start_prod};
				end_mark_nxt   = {1'b0, length_prod} + {1'b0, start_prod};
			end
			if (roll_nxt == ROLL_LEADIN && roll_ticks_nxt >= {7'd0, start_mark_nxt}) begin
				roll_nxt = ROLL_PULSE;
			end
			if (roll_nxt == ROLL_PULSE) begin
				if (roll_ticks_nxt > {7'd0, end_mark_nxt}) begin
					roll_nxt = ROLL_DONE;
				end else begin
					left_res = LEFT_NEUTRAL + {{3{cfg.roll_offset[12]}}, cfg.roll_offset};
				end
			end
		end
	end

	// Update state per transaction type
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glide_q        <= GLIDE_HOLD;
			roll_q         <= ROLL_WAIT;
			target_q       <= '0;
			level_q        <= '0;
			hall_seen_q    <= 1'b0;
			edge_ticks_q   <= '0;
			last_period_q  <= '0;
			avg_period_q   <= '0;
			roll_ticks_q   <= '0;
			start_mark_q   <= '0;
			end_mark_q     <= '0;
			glide_was_q    <= 1'b0;
			roll_was_q     <= 1'b0;
		end else if (advance) begin
			unique case (req_type_s1)
				REQ_TICK: begin
					if (edge_ticks_q != '1) edge_ticks_q <= edge_ticks_q + 16'd1;
					if (roll_ticks_q != '1) roll_ticks_q <= roll_ticks_q + 32'd1;
				end
				REQ_HALL: begin
					// Average the new period with the one before it
					hall_seen_q    <= 1'b1;
					last_period_q  <= edge_ticks_q;
					avg_period_q   <= 16'(({1'b0, edge_ticks_q} + {1'b0, last_period_q}) >> 1);
					edge_ticks_q   <= '0;
				end
				REQ_CTRL: begin
					glide_q      <= glide_nxt;
					roll_q       <= roll_nxt;
					target_q     <= target_nxt;
					level_q      <= level_nxt;
					roll_ticks_q <= roll_ticks_nxt;
					start_mark_q <= start_mark_nxt;
					end_mark_q   <= end_mark_nxt;
					glide_was_q  <= glide_en_s1;
					roll_was_q   <= roll_en_s1;
					hall_seen_q  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Result register: load on a control update, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
		end else if (advance && is_ctrl_s1) begin
			res.valid <= 1'b1;
		end else if (res.ready) begin
			res.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_ctrl_s1) begin
			res.throttle_out      <= thr_res;
			res.left_aileron_out  <= left_res;
			res.right_aileron_out <= right_res;
			res.glide_state_out   <= glide_code(glide_nxt);
			res.roll_state_out    <= roll_code(roll_nxt);
		end
	end

	// A new result only follows a control update
	a_result_from_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(advance && is_ctrl_s1))
		else $error("result raised without a control update");

	// Hall flag is consumed by every control update
	a_hall_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && is_ctrl_s1) |=> !hall_seen_q)
		else $error("hall flag survived a control update");

	// Ramp level never passes the target
	a_level_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= target_q)
		else $error("throttle level above target");

	// Input stalls only behind a result not yet taken
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (res.valid && !res.ready))
		else $error("input stalled without output back-pressure");

endmodule
